// File: hdl/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and control/status types for the LFU cache engine.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned KEY_W          = 32;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned CAP_W          = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, start search
        logic scan;     // advance search by one entry
        logic commit;   // update state and present result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } t_stat;

endpackage : lfu_pkg
`default_nettype wire

// File: hdl/lfu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: load, walk the entries one per cycle, then commit.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  lfu_pkg::t_stat     i_stat,
    output lfu_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule : lfu_ctrl
`default_nettype wire

// File: hdl/lfu_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_dpath
// Entry store, serial key match / victim search, and state update.
// ----------------------------------------------------------------------------
module lfu_dpath #(
    parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  lfu_pkg::t_cmd                      i_cmd,
    output lfu_pkg::t_stat                     o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_opcode,
    input  wire logic [lfu_pkg::KEY_W-1:0]     i_key,
    input  wire logic [lfu_pkg::DATA_W-1:0]    i_value,
    output logic                               o_done,
    output logic                               o_hit,
    output logic [lfu_pkg::DATA_W-1:0]         o_read_value,
    output logic                               o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]          o_evicted_key,
    output logic                               o_dropped
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OW = $clog2(ENTRIES + 1);
    localparam int unsigned CW = lfu_pkg::CAP_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // entry store
    logic [ENTRIES-1:0]                r_valid;
    logic [lfu_pkg::KEY_W-1:0]         r_ekey  [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]        r_edata [ENTRIES];
    logic [COUNT_BITS-1:0]             r_ecnt  [ENTRIES];
    logic [IW-1:0]                     r_erank [ENTRIES];
    logic [OW-1:0]                     r_occ;
    logic [CW-1:0]                     r_cap;

    // request and search registers
    logic                              r_op;
    logic [lfu_pkg::KEY_W-1:0]         r_key;
    logic [lfu_pkg::DATA_W-1:0]        r_val;
    logic [IW-1:0]                     r_idx;
    logic                              r_hit;
    logic [IW-1:0]                     r_hidx;
    logic                              r_vfound;
    logic [IW-1:0]                     r_vidx;
    logic                              r_ffound;
    logic [IW-1:0]                     r_fidx;

    logic [OW-1:0] eff_cap;
    assign eff_cap = (32'(r_cap) > ENTRIES) ? OW'(ENTRIES) : OW'(r_cap);

    assign o_stat.scan_last = (r_idx == IW'(ENTRIES - 1));

    // scan step over entry r_idx
    logic better;
    always_comb begin
        better = !r_vfound
              || (r_ecnt[r_idx] < r_ecnt[r_vidx])
              || ((r_ecnt[r_idx] == r_ecnt[r_vidx]) && (r_erank[r_idx] > r_erank[r_vidx]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lfu_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_key    <= i_key;
            r_val    <= i_value;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_vfound <= 1'b0;
            r_ffound <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (r_valid[r_idx]) begin
                if (r_ekey[r_idx] == r_key && !r_hit) begin
                    r_hit  <= 1'b1;
                    r_hidx <= r_idx;
                end
                if (better) begin
                    r_vfound <= 1'b1;
                    r_vidx   <= r_idx;
                end
            end else if (!r_ffound) begin
                r_ffound <= 1'b1;
                r_fidx   <= r_idx;
            end
            if (!o_stat.scan_last) r_idx <= r_idx + 1'b1;
        end
    end

    // commit decisions
    logic touch, ins, evict, drop;
    logic [IW-1:0] slot;
    always_comb begin
        touch = 1'b0; ins = 1'b0; evict = 1'b0; drop = 1'b0;
        slot  = r_fidx;
        if (r_op == lfu_pkg::OP_GET) begin
            touch = r_hit;
        end else if (eff_cap == '0) begin
            drop = 1'b1;
        end else if (r_hit) begin
            touch = 1'b1;
        end else if (r_occ < eff_cap && r_ffound) begin
            ins = 1'b1;
        end else if (r_vfound) begin
            ins = 1'b1; evict = 1'b1; slot = r_vidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_cmd.commit) begin
            if (ins && !evict) r_occ <= r_occ + 1'b1;
            if (ins) r_valid[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (touch) begin
                    if (IW'(i) == r_hidx) begin
                        r_erank[i] <= '0;
                        if (r_ecnt[i] != CMAX) r_ecnt[i] <= r_ecnt[i] + 1'b1;
                        if (r_op == lfu_pkg::OP_PUT) r_edata[i] <= r_val;
                    end else if (r_valid[i] && r_erank[i] < r_erank[r_hidx]) begin
                        r_erank[i] <= r_erank[i] + 1'b1;
                    end
                end else if (ins) begin
                    if (IW'(i) == slot) begin
                        r_ekey[i]  <= r_key;
                        r_edata[i] <= r_val;
                        r_ecnt[i]  <= COUNT_BITS'(1);
                        r_erank[i] <= '0;
                    end else if (r_valid[i]) begin
                        // evicted: ranks above victim drop one, then all age one
                        if (!(evict && r_erank[i] > r_erank[slot]))
                            r_erank[i] <= r_erank[i] + 1'b1;
                    end
                end
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.commit;
        end
        if (i_cmd.commit) begin
            o_hit         <= r_hit;
            o_read_value  <= (r_op == lfu_pkg::OP_GET && r_hit) ? r_edata[r_hidx] : '0;
            o_evicted     <= evict;
            o_evicted_key <= evict ? r_ekey[slot] : '0;
            o_dropped     <= drop;
        end
    end

endmodule : lfu_dpath
`default_nettype wire

// File: hdl/lfu_cache_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_engine_unit
// LFU key/value cache, ties broken least recently used.
// ----------------------------------------------------------------------------
// A new request is taken only once the last one is through: busy stays high
// through the one-entry-a-cycle search over the store for key match, free slot
// and victim together, and through the commit.
// Result beat lasts one cycle on o_done; the receiver cannot stall.
// Reset (synchronous, active low): all entries invalid, capacity 16.
// ----------------------------------------------------------------------------
module lfu_cache_engine_unit #(
    parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfu_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_opcode,
    input  wire logic [lfu_pkg::KEY_W-1:0]     i_key,
    input  wire logic [lfu_pkg::DATA_W-1:0]    i_value,
    output logic                               o_done,
    output logic                               o_hit,
    output logic [lfu_pkg::DATA_W-1:0]         o_read_value,
    output logic                               o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]          o_evicted_key,
    output logic                               o_dropped
);

    lfu_pkg::t_cmd  cmd;
    lfu_pkg::t_stat stat;

    // sequencer: take the beat, walk the store, commit
    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // store and search
    lfu_dpath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_dropped     (o_dropped)
    );

endmodule : lfu_cache_engine_unit
`default_nettype wire

// File: verif/lfu_cache_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_engine_unit_tb
// Self-checking bench for the LFU cache engine: a behavioural cache model
// predicts hit, read value, victim key and drop flag for every accepted beat,
// and a scoreboard checks each o_done beat against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    logic        dropped;
} lfu_result_t;

class lfu_scoreboard;
    localparam int N = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    bit          valid_q [N];
    logic [31:0] key_q   [N];
    logic [31:0] data_q  [N];
    logic [15:0] count_q [N];
    int          rank_q  [N];
    int          occupied;
    int          capacity;
    lfu_result_t pending[$];
    int          errors;
    int          n_hits, n_evicts, n_drops, n_beats;

    function new();
        capacity = 16;
        occupied = 0;
        errors   = 0;
        foreach (valid_q[i]) valid_q[i] = 1'b0;
    endfunction

    function void set_capacity(logic [4:0] c);
        capacity = int'(c);
    endfunction

    // Promote entry e to most recent and bump its use count.
    function void promote(int e);
        foreach (valid_q[i])
            if (valid_q[i] && i != e && rank_q[i] < rank_q[e]) rank_q[i]++;
        rank_q[e] = 0;
        if (count_q[e] != CNT_MAX) count_q[e]++;
    endfunction

    // Note an accepted request and queue the result it must produce.
    function void note_request(logic op, logic [31:0] k, logic [31:0] v);
        lfu_result_t r;
        int cap, e, slot, vic, rk;
        cap  = (capacity > N) ? N : capacity;
        e    = -1;
        slot = -1;
        vic  = -1;
        r    = '0;
        foreach (valid_q[i]) if (e < 0 && valid_q[i] && key_q[i] == k) e = i;
        r.hit = (e >= 0);
        if (op == lfu_pkg::OP_GET) begin
            if (e >= 0) begin
                r.read_value = data_q[e];
                promote(e);
            end
        end else if (cap == 0) begin
            r.dropped = 1'b1;
        end else if (e >= 0) begin
            promote(e);
            data_q[e] = v;
        end else begin
            if (occupied < cap)
                foreach (valid_q[i]) if (slot < 0 && !valid_q[i]) slot = i;
            if (slot < 0) begin
                foreach (valid_q[i]) begin
                    if (valid_q[i] && (vic < 0 || count_q[i] < count_q[vic] ||
                        (count_q[i] == count_q[vic] && rank_q[i] > rank_q[vic])))
                        vic = i;
                end
                slot = vic;
                rk = rank_q[slot];
                r.evicted     = 1'b1;
                r.evicted_key = key_q[slot];
                valid_q[slot] = 1'b0;
                foreach (valid_q[i]) if (valid_q[i] && rank_q[i] > rk) rank_q[i]--;
                occupied--;
            end
            foreach (valid_q[i]) if (valid_q[i]) rank_q[i]++;
            valid_q[slot] = 1'b1;
            key_q[slot]   = k;
            data_q[slot]  = v;
            count_q[slot] = 16'd1;
            rank_q[slot]  = 0;
            occupied++;
        end
        pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(lfu_result_t act);
        lfu_result_t exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, act);
            errors++;
            return;
        end
        exp = pending.pop_front();
        n_beats++;
        if (exp.hit) n_hits++;
        if (exp.evicted) n_evicts++;
        if (exp.dropped) n_drops++;
        if (exp.hit != act.hit)
            $display("%0t: hit exp %0b act %0b", $time, exp.hit, act.hit);
        if (exp.read_value != act.read_value)
            $display("%0t: read_value exp %h act %h", $time, exp.read_value,
                     act.read_value);
        if (exp.evicted != act.evicted)
            $display("%0t: evicted exp %0b act %0b", $time, exp.evicted, act.evicted);
        if (exp.evicted_key != act.evicted_key)
            $display("%0t: evicted_key exp %h act %h", $time, exp.evicted_key,
                     act.evicted_key);
        if (exp.dropped != act.dropped)
            $display("%0t: dropped exp %0b act %0b", $time, exp.dropped, act.dropped);
        if (exp != act) errors++;
    endfunction
endclass

module lfu_cache_engine_unit_tb;

    localparam int  LIMIT_CYCLES = 400000;

    logic                       i_clk = 0;
    logic                       i_rst_n = 0;
    logic                       start = 0;
    logic                       busy;
    logic                       i_cfg_we = 0;
    logic [lfu_pkg::CAP_W-1:0]  i_cfg_wdata = '0;
    logic                       i_opcode = 0;
    logic [lfu_pkg::KEY_W-1:0]  i_key = '0;
    logic [lfu_pkg::DATA_W-1:0] i_value = '0;
    logic                       o_done, o_hit, o_evicted, o_dropped;
    logic [lfu_pkg::DATA_W-1:0] o_read_value;
    logic [lfu_pkg::KEY_W-1:0]  o_evicted_key;

    lfu_scoreboard cache_sb = new();
    int            cycle_count = 0;
    logic [31:0]   key_pool[$];

    always #4 i_clk = ~i_clk;

    lfu_cache_engine_unit dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_wdata,
        .i_opcode, .i_key, .i_value, .o_done, .o_hit, .o_read_value,
        .o_evicted, .o_evicted_key, .o_dropped
    );

    // Sample result beats at the rising edge; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            cache_sb.check_result('{o_hit, o_read_value, o_evicted, o_evicted_key,
                                    o_dropped});
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle a random stretch: mostly short, now and then long.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge i_clk);
    endtask

    // Present one request beat and hold it until the block takes it.
    task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
        i_opcode = op;
        i_key    = k;
        i_value  = v;
        start    = 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cache_sb.note_request(op, k, v);
        @(negedge i_clk);
        start = 0;
        i_opcode = 1'($urandom());
        i_key    = $urandom();
        i_value  = $urandom();
    endtask

    // Drain every outstanding result, then let the engine settle.
    task automatic wait_drained();
        while (cache_sb.pending.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    // Write capacity only while the engine is idle.
    task automatic write_capacity(logic [4:0] c);
        wait_drained();
        i_cfg_we    = 1;
        i_cfg_wdata = c;
        @(negedge i_clk);
        i_cfg_we = 0;
        cache_sb.set_capacity(c);
    endtask

    // Pick a key: mostly from a small reused pool so hits and victims happen.
    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    task automatic random_phase(int n_items, int pool_size);
        key_pool.delete();
        repeat (pool_size) key_pool.push_back($urandom());
        for (int i = 0; i < n_items; i++) begin
            idle_gap();
            send_request(1'($urandom_range(0, 1)), pick_key(), $urandom());
        end
    endtask

    initial begin
        logic [4:0] caps[8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd2, 5'd9};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: extremes of key and value, get miss/hit, update, a stored
        // all-ones value, saturation-free evictions at the reset capacity of 16.
        send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
        send_request(lfu_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
        send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 17; i++) send_request(lfu_pkg::OP_PUT, 32'h100 + i, i);
        write_capacity(5'd2);          // lowered below occupancy
        send_request(lfu_pkg::OP_PUT, 32'h5555_AAAA, 32'h1);
        write_capacity(5'd0);          // every put dropped, gets still served
        send_request(lfu_pkg::OP_PUT, 32'h5555_AAAA, 32'h2);
        send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0);

        // Random phases over several capacities, extremes among them.
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            random_phase(190, (c % 2) ? 6 : 24);
            if (c == 3) wait_drained();  // sender holds off until all results in
        end

        wait_drained();
        $display("Covered %0d results: %0d hits, %0d evictions, %0d dropped puts,",
                 cache_sb.n_beats, cache_sb.n_hits, cache_sb.n_evicts, cache_sb.n_drops);
        $display("over capacities 0, 1, 2, 4, 9, 16 and above-range settings.");
        if (cache_sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: lfu_cache_engine_unit.f
hdl/lfu_pkg.sv
hdl/lfu_ctrl.sv
hdl/lfu_dpath.sv
hdl/lfu_cache_engine_unit.sv
verif/lfu_cache_engine_unit_tb.sv
